@@ design/adpcmbd_pkg.sv @@
// Shared types and constants for the byte-wise ADPCM sample decoder.
// Used by the code decoder, the register block, the top level and the port checker; no dependencies.
package adpcmbd_pkg;

	localparam int WORD_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int STEP_W   = 2;
	localparam int IDX_W    = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [STEP_W-1:0] STEP_MAX   = 2'd3;
	localparam logic [BYTE_W-1:0] SAMPLE_MAX = 8'd255;

	// Register index of decode_mode (byte address 4 * index).
	localparam logic [PADDR_W-3:0] REG_DECODE_MODE = 1'b0;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_2BIT = 2'd1,
		MODE_3BIT = 2'd2,
		MODE_4BIT = 2'd3
	} mode_t;

	// Predictor state carried from one code to the next.
	typedef struct packed {
		logic [BYTE_W-1:0] ref_sample;
		logic [STEP_W-1:0] step;
	} pred_t;

endpackage

@@ design/adpcmbd_code.sv @@
// One ADPCM code step: selects the code for the current position in the byte,
// applies it to the predictor state and clamps. Depends on adpcmbd_pkg.
module adpcmbd_code (
	input  adpcmbd_pkg::mode_t                      mode,
	input  logic [adpcmbd_pkg::IDX_W-1:0]           idx,
	input  logic [adpcmbd_pkg::BYTE_W-1:0]          code_byte,
	input  adpcmbd_pkg::pred_t                      cur,
	output adpcmbd_pkg::pred_t                      nxt,
	output logic                                    code_last
);
	import adpcmbd_pkg::*;

	logic [2:0] mag;
	logic       neg;
	logic [2:0] extra;
	logic       rise;
	logic [2:0] shift;
	logic [9:0] delta;
	logic [9:0] sum;

	always_comb begin
		mag       = 3'd0;
		neg       = 1'b0;
		extra     = 3'd0;
		rise      = 1'b0;
		code_last = 1'b1;
		unique case (mode)
			MODE_2BIT: begin
				unique case (idx)
					2'd0: {neg, mag[0]} = code_byte[7:6];
					2'd1: {neg, mag[0]} = code_byte[5:4];
					2'd2: {neg, mag[0]} = code_byte[3:2];
					2'd3: {neg, mag[0]} = code_byte[1:0];
					default: {neg, mag[0]} = 2'b00;
				endcase
				extra     = 3'd2;
				rise      = (mag >= 3'd1);
				code_last = (idx == 2'd3);
			end
			MODE_3BIT: begin
				unique case (idx)
					2'd0:    {neg, mag[1:0]} = code_byte[7:5];
					2'd1:    {neg, mag[1:0]} = code_byte[4:2];
					default: {neg, mag[1:0]} = {code_byte[1:0], 1'b0};
				endcase
				rise      = (mag >= 3'd3);
				code_last = (idx == 2'd2);
			end
			MODE_4BIT: begin
				{neg, mag} = idx[0] ? code_byte[3:0] : code_byte[7:4];
				rise       = (mag >= 3'd5);
				code_last  = idx[0];
			end
			MODE_RAW: begin
				code_last = 1'b1;
			end
			default: code_last = 1'b1;
		endcase
	end

	assign shift = 3'({1'b0, cur.step}) + extra;
	assign delta = 10'(mag) << shift;
	assign sum   = neg ? (10'(cur.ref_sample) - delta) : (10'(cur.ref_sample) + delta);

	always_comb begin
		// Bit 9 set means the sum went below zero; bit 8 means above the byte range.
		if (sum[9]) begin
			nxt.ref_sample = '0;
		end else if (sum[8]) begin
			nxt.ref_sample = SAMPLE_MAX;
		end else begin
			nxt.ref_sample = sum[7:0];
		end

		if (rise) begin
			nxt.step = (cur.step == STEP_MAX) ? STEP_MAX : cur.step + 2'd1;
		end else if (mag == 3'd0) begin
			nxt.step = (cur.step == '0) ? '0 : cur.step - 2'd1;
		end else begin
			nxt.step = cur.step;
		end
	end

endmodule

@@ design/adpcmbd_regs.sv @@
// APB-style configuration register block holding decode_mode.
// Depends on adpcmbd_pkg.
module adpcmbd_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adpcmbd_pkg::PADDR_W-1:0]     paddr,
	input  logic [adpcmbd_pkg::PDATA_W-1:0]     pwdata,
	output logic [adpcmbd_pkg::PDATA_W-1:0]     prdata,
	output logic                                pready,
	output adpcmbd_pkg::mode_t                  mode
);
	import adpcmbd_pkg::*;

	mode_t mode_q;
	logic  sel_mode;

	assign sel_mode = (paddr[PADDR_W-1:2] == REG_DECODE_MODE);
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RAW;
		end else if (psel && penable && pwrite && sel_mode) begin
			mode_q <= mode_t'(pwdata[1:0]);
		end
	end

	assign prdata = sel_mode ? PDATA_W'(mode_q) : '0;
	assign mode   = mode_q;

endmodule

@@ design/adpcm_byte_decoder_core.sv @@
// Byte-wise 8-bit ADPCM decoder, top level.
// Input register, one-code-per-cycle decode step unless stalled, output register.
// Depends on adpcmbd_pkg, adpcmbd_code and adpcmbd_regs.
//
// Usage:
//   Requests enter on data_word/load_reference under in_valid/in_ready and
//   leave as sample/last under out_valid/out_ready; last marks the final
//   sample of a request. decode_mode sits at byte address 0 of the APB port.
//   Raw mode gives one sample per request; two-bit, three-bit and four-bit
//   ADPCM give four, three and two samples.
//   The first sample of a request passes through the input register and the
//   decode step into the output register. Throughput: one sample per cycle
//   while the output is not stalled; the chain through the reference sample
//   and step index allows one code per cycle. A new request is taken in the
//   cycle its predecessor's last code is decoded, so back-to-back requests
//   stream without gaps. Reset clears reference sample, step index and
//   decode_mode and drops any request in flight. When out_ready is low with
//   a sample held, the output register holds and decoding stalls; in_ready
//   stays low while a held request is not finishing.
module adpcm_byte_decoder_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [adpcmbd_pkg::PADDR_W-1:0]     paddr,
	input  logic [adpcmbd_pkg::PDATA_W-1:0]     pwdata,
	output logic [adpcmbd_pkg::PDATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [adpcmbd_pkg::WORD_W-1:0]      data_word,
	input  logic                                load_reference,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [adpcmbd_pkg::WORD_W-1:0]      sample,
	output logic                                last
);
	import adpcmbd_pkg::*;

	mode_t              mode;
	logic               valid_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               load_s1;
	logic [IDX_W-1:0]   idx_q;
	pred_t              pred_q;
	pred_t              cur;
	pred_t              nxt;
	logic               code_last;
	logic               advance;
	logic               valid_s2;
	logic [WORD_W-1:0]  sample_s2;
	logic               last_s2;

	adpcmbd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	// Outside raw mode, a reference load applies before the first code of a flagged request.
	always_comb begin
		if (load_s1 && (idx_q == '0) && (mode != MODE_RAW)) begin
			cur.ref_sample = word_s1[BYTE_W-1:0];
			cur.step       = '0;
		end else begin
			cur = pred_q;
		end
	end

	adpcmbd_code u_code (
		.mode      (mode),
		.idx       (idx_q),
		.code_byte (word_s1[BYTE_W-1:0]),
		.cur       (cur),
		.nxt       (nxt),
		.code_last (code_last)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || (advance && code_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			pred_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance && code_last) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				idx_q    <= code_last ? '0 : idx_q + 2'd1;
				valid_s2 <= 1'b1;
				if (mode != MODE_RAW) begin
					pred_q <= nxt;
				end
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= data_word;
			load_s1 <= load_reference;
		end
		if (advance) begin
			sample_s2 <= (mode == MODE_RAW) ? word_s1 : WORD_W'(nxt.ref_sample);
			last_s2   <= code_last;
		end
	end

	assign out_valid = valid_s2;
	assign sample    = sample_s2;
	assign last      = last_s2;

endmodule

@@ design/adpcmbd_checker.sv @@
// Port-level checker for the ADPCM byte decoder, bound to the top level.
// Depends on adpcmbd_pkg and adpcm_byte_decoder_core.
module adpcmbd_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pready,
	input  logic                                in_ready,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [adpcmbd_pkg::WORD_W-1:0]      sample,
	input  logic                                last
);
	import adpcmbd_pkg::*;

	// Hold a stalled sample.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last))
		else $error("output changed while stalled");

	// A taken non-final sample is followed at once by the next one.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a request's samples");

	// A stalled non-final sample blocks new requests.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !last |-> !in_ready)
		else $error("request accepted while previous one unfinished");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind adpcm_byte_decoder_core adpcmbd_checker u_adpcmbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample    (sample),
	.last      (last)
);
